### rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/fcgl_pkg.sv
// Types and constants for the cmap glyph lookup block.
`default_nettype none
package fcgl_pkg;

   localparam int ADDR_W = 38;   // widest computed byte address (format 12 group walk)

   localparam logic [1:0] FMT_12 = 2'd0;
   localparam logic [1:0] FMT_4  = 2'd1;
   localparam logic [1:0] FMT_6  = 2'd2;

   localparam logic [ADDR_W-1:0] F12_NGROUPS_OFS = 38'd12;
   localparam logic [ADDR_W-1:0] F12_GROUPS_OFS  = 38'd16;
   localparam logic [ADDR_W-1:0] F4_SEGX2_OFS    = 38'd6;
   localparam logic [ADDR_W-1:0] F4_ENDC_OFS     = 38'd14;
   localparam logic [ADDR_W-1:0] F6_FIRST_OFS    = 38'd6;
   localparam logic [ADDR_W-1:0] F6_COUNT_OFS    = 38'd8;
   localparam logic [ADDR_W-1:0] F6_ARRAY_OFS    = 38'd10;
   localparam logic [20:0]       BMP_MAX         = 21'h00FFFF;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_RD   = 5'b00010,
      ST_WT   = 5'b00100,
      ST_STEP = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   typedef enum logic [15:0] {
      PH_F12_HI    = 16'h0001,
      PH_F12_CHK   = 16'h0002,
      PH_F12_ISSUE = 16'h0004,
      PH_F12_SC    = 16'h0008,
      PH_F12_EC    = 16'h0010,
      PH_F12_SG    = 16'h0020,
      PH_F4_SEGX2  = 16'h0040,
      PH_F4_CHK    = 16'h0080,
      PH_F4_END    = 16'h0100,
      PH_F4_START  = 16'h0200,
      PH_F4_DELTA  = 16'h0400,
      PH_F4_RO     = 16'h0800,
      PH_F4_G      = 16'h1000,
      PH_F6_FIRST  = 16'h2000,
      PH_F6_COUNT  = 16'h4000,
      PH_F6_G      = 16'h8000
   } phase_type;

endpackage
`default_nettype wire

### rtl/font_cmap_glyph_lookup_top.sv
// Top level of the cmap glyph lookup: subtable byte memory and lookup sequencer.
//
//  channel  | direction | ports
//  request  | in        | req_valid, req_stall, req_action, req_byte_address,
//           |           | req_byte_value, req_codepoint
//  response | out       | rsp_valid, rsp_stall, rsp_glyph_id, rsp_read_overflow
//  csr      | in        | csr_write_enable, csr_write_data (subtable format)
//
// A lookup reads the subtable one byte at a time on the single memory port (states ST_RD
// then ST_WT for each byte), then runs a step state for each field.
// req_stall is high while a lookup runs or its result waits to enter the output register.
// Reset is synchronous and clears control and the format register; memory is not cleared.
`default_nettype none
module font_cmap_glyph_lookup_top #(
   parameter int MEM_ADDR_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [15:0] req_byte_address,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic [20:0] req_codepoint,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_glyph_id,
   output logic             rsp_read_overflow,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_write_data
);
   import fcgl_pkg::*;

   localparam logic [ADDR_W-1:0] MEM_SIZE = ADDR_W'(1) << MEM_ADDR_BITS;

   logic [7:0] mem [2**MEM_ADDR_BITS];
   logic [7:0] mem_q_ff;

   state_type state_ff, state_in;
   phase_type ph_ff, ph_in;
   logic [1:0]        fmt_ff;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [2:0]        rd_cnt_ff, rd_cnt_in;
   logic [31:0]       acc_ff, acc_in;
   logic [20:0]       cp_ff, cp_in;
   logic [32:0]       lo_ff, lo_in, hi_ff, hi_in;
   logic [31:0]       mid_ff, mid_in;
   logic [ADDR_W-1:0] g_ff, g_in;
   logic [31:0]       sc_ff, sc_in;
   logic [15:0]       segx2_ff, segx2_in;
   logic [15:0]       i_ff, i_in;
   logic [17:0]       startc_ff, startc_in, deltas_ff, deltas_in, ranges_ff, ranges_in;
   logic [15:0]       startv_ff, startv_in, delta_ff, delta_in, first_ff, first_in;
   logic [31:0]       res_glyph_ff, res_glyph_in;
   logic              res_ovf_ff, res_ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_glyph_ff, rsp_glyph_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic              mem_we;
   logic [31:0]       wr_addr_ext;
   logic              wr_in_range;
   logic              rsp_free;

   assign wr_addr_ext = 32'(req_byte_address);
   assign wr_in_range = (wr_addr_ext >> MEM_ADDR_BITS) == 32'd0;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_glyph_id      = rsp_glyph_ff;
   assign rsp_read_overflow = rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr_ext[MEM_ADDR_BITS-1:0]] <= req_byte_value;
      end
      mem_q_ff <= mem[rd_addr_ff[MEM_ADDR_BITS-1:0]];
   end

   always_comb begin
      logic              go_rd;
      logic [ADDR_W-1:0] go_addr;
      logic [2:0]        go_cnt;
      phase_type         go_ph;
      logic              fin;
      logic [31:0]       fin_glyph;
      logic              fin_ovf;
      logic [16:0]       f6_end;
      logic [15:0]       ro;

      go_rd     = 1'b0;
      go_addr   = '0;
      go_cnt    = '0;
      go_ph     = ph_ff;
      fin       = 1'b0;
      fin_glyph = '0;
      fin_ovf   = 1'b0;
      f6_end    = 17'(first_ff) + 17'(acc_ff[15:0]);
      ro        = acc_ff[15:0];
      mem_we    = 1'b0;

      state_in     = state_ff;
      ph_in        = ph_ff;
      rd_addr_in   = rd_addr_ff;
      rd_cnt_in    = rd_cnt_ff;
      acc_in       = acc_ff;
      cp_in        = cp_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      g_in         = g_ff;
      sc_in        = sc_ff;
      segx2_in     = segx2_ff;
      i_in         = i_ff;
      startc_in    = startc_ff;
      deltas_in    = deltas_ff;
      ranges_in    = ranges_ff;
      startv_in    = startv_ff;
      delta_in     = delta_ff;
      first_in     = first_ff;
      res_glyph_in = res_glyph_ff;
      res_ovf_in   = res_ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_action) begin
                  mem_we = wr_in_range;
               end else begin
                  cp_in = req_codepoint;
                  case (fmt_ff)
                     FMT_12: begin
                        go_rd = 1'b1; go_addr = F12_NGROUPS_OFS; go_cnt = 3'd4;
                        go_ph = PH_F12_HI;
                     end
                     FMT_4: begin
                        if (req_codepoint > BMP_MAX) begin
                           fin = 1'b1;
                        end else begin
                           go_rd = 1'b1; go_addr = F4_SEGX2_OFS; go_cnt = 3'd2;
                           go_ph = PH_F4_SEGX2;
                        end
                     end
                     FMT_6: begin
                        go_rd = 1'b1; go_addr = F6_FIRST_OFS; go_cnt = 3'd2;
                        go_ph = PH_F6_FIRST;
                     end
                     default: fin = 1'b1;
                  endcase
               end
            end
         end
         ST_RD: begin
            if (rd_addr_ff >= MEM_SIZE) begin
               fin     = 1'b1;
               fin_ovf = 1'b1;
            end else begin
               state_in = ST_WT;
            end
         end
         ST_WT: begin
            acc_in     = {acc_ff[23:0], mem_q_ff};
            rd_addr_in = rd_addr_ff + ADDR_W'(1);
            rd_cnt_in  = rd_cnt_ff - 3'd1;
            state_in   = (rd_cnt_ff == 3'd1) ? ST_STEP : ST_RD;
         end
         ST_STEP: begin
            case (ph_ff)
               PH_F12_HI: begin
                  lo_in = '0;
                  hi_in = 33'(acc_ff);
                  ph_in = PH_F12_CHK;
               end
               PH_F12_CHK: begin
                  if (lo_ff < hi_ff) begin
                     mid_in = 32'(lo_ff + ((hi_ff - lo_ff) >> 1));
                     ph_in  = PH_F12_ISSUE;
                  end else begin
                     fin = 1'b1;
                  end
               end
               PH_F12_ISSUE: begin
                  // group record is 12 bytes: mid*8 + mid*4
                  g_in  = F12_GROUPS_OFS + (ADDR_W'(mid_ff) << 3) + (ADDR_W'(mid_ff) << 2);
                  go_rd = 1'b1;
                  go_addr = F12_GROUPS_OFS + (ADDR_W'(mid_ff) << 3) + (ADDR_W'(mid_ff) << 2);
                  go_cnt = 3'd4; go_ph = PH_F12_SC;
               end
               PH_F12_SC: begin
                  sc_in = acc_ff;
                  go_rd = 1'b1; go_addr = g_ff + ADDR_W'(4); go_cnt = 3'd4;
                  go_ph = PH_F12_EC;
               end
               PH_F12_EC: begin
                  if (32'(cp_ff) < sc_ff) begin
                     hi_in = 33'(mid_ff);
                     ph_in = PH_F12_CHK;
                  end else if (32'(cp_ff) > acc_ff) begin
                     lo_in = 33'(mid_ff) + 33'd1;
                     ph_in = PH_F12_CHK;
                  end else begin
                     go_rd = 1'b1; go_addr = g_ff + ADDR_W'(8); go_cnt = 3'd4;
                     go_ph = PH_F12_SG;
                  end
               end
               PH_F12_SG: begin
                  fin       = 1'b1;
                  fin_glyph = acc_ff + (32'(cp_ff) - sc_ff);
               end
               PH_F4_SEGX2: begin
                  segx2_in  = acc_ff[15:0];
                  i_in      = '0;
                  startc_in = 18'd16 + 18'(acc_ff[15:0]);
                  deltas_in = 18'd16 + (18'(acc_ff[15:0]) << 1);
                  ranges_in = 18'd16 + (18'(acc_ff[15:0]) << 1) + 18'(acc_ff[15:0]);
                  ph_in     = PH_F4_CHK;
               end
               PH_F4_CHK: begin
                  if (i_ff < (segx2_ff >> 1)) begin
                     go_rd = 1'b1;
                     go_addr = F4_ENDC_OFS + (ADDR_W'(i_ff) << 1);
                     go_cnt = 3'd2; go_ph = PH_F4_END;
                  end else begin
                     fin = 1'b1;
                  end
               end
               PH_F4_END: begin
                  if (32'(cp_ff) > acc_ff) begin
                     i_in  = i_ff + 16'd1;
                     ph_in = PH_F4_CHK;
                  end else begin
                     go_rd = 1'b1;
                     go_addr = ADDR_W'(startc_ff) + (ADDR_W'(i_ff) << 1);
                     go_cnt = 3'd2; go_ph = PH_F4_START;
                  end
               end
               PH_F4_START: begin
                  if (32'(cp_ff) < acc_ff) begin
                     fin = 1'b1;
                  end else begin
                     startv_in = acc_ff[15:0];
                     go_rd = 1'b1;
                     go_addr = ADDR_W'(deltas_ff) + (ADDR_W'(i_ff) << 1);
                     go_cnt = 3'd2; go_ph = PH_F4_DELTA;
                  end
               end
               PH_F4_DELTA: begin
                  delta_in = acc_ff[15:0];
                  go_rd = 1'b1;
                  go_addr = ADDR_W'(ranges_ff) + (ADDR_W'(i_ff) << 1);
                  go_cnt = 3'd2; go_ph = PH_F4_RO;
               end
               PH_F4_RO: begin
                  if (ro == 16'd0) begin
                     fin       = 1'b1;
                     fin_glyph = 32'(16'(cp_ff[15:0] + delta_ff));
                  end else begin
                     go_rd = 1'b1;
                     go_addr = ADDR_W'(ranges_ff) + (ADDR_W'(i_ff) << 1) + ADDR_W'(ro)
                             + (ADDR_W'(cp_ff[15:0] - startv_ff) << 1);
                     go_cnt = 3'd2; go_ph = PH_F4_G;
                  end
               end
               PH_F4_G: begin
                  fin = 1'b1;
                  if (acc_ff[15:0] != 16'd0) begin
                     fin_glyph = 32'(16'(acc_ff[15:0] + delta_ff));
                  end
               end
               PH_F6_FIRST: begin
                  first_in = acc_ff[15:0];
                  go_rd = 1'b1; go_addr = F6_COUNT_OFS; go_cnt = 3'd2;
                  go_ph = PH_F6_COUNT;
               end
               PH_F6_COUNT: begin
                  if (cp_ff < 21'(first_ff) || cp_ff >= 21'(f6_end)) begin
                     fin = 1'b1;
                  end else begin
                     go_rd = 1'b1;
                     go_addr = F6_ARRAY_OFS + (ADDR_W'(cp_ff - 21'(first_ff)) << 1);
                     go_cnt = 3'd2; go_ph = PH_F6_G;
                  end
               end
               PH_F6_G: begin
                  fin       = 1'b1;
                  fin_glyph = acc_ff;
               end
               default: fin = 1'b1;
            endcase
         end
         ST_FIN: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (go_rd) begin
         rd_addr_in = go_addr;
         rd_cnt_in  = go_cnt;
         ph_in      = go_ph;
         acc_in     = '0;
         state_in   = ST_RD;
      end
      if (fin) begin
         res_glyph_in = fin_glyph;
         res_ovf_in   = fin_ovf;
         state_in     = ST_FIN;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_glyph_in = rsp_glyph_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (state_ff == ST_FIN && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_glyph_in = res_glyph_ff;
         rsp_ovf_in   = res_ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fmt_ff       <= FMT_12;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            fmt_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      ph_ff        <= ph_in;
      rd_addr_ff   <= rd_addr_in;
      rd_cnt_ff    <= rd_cnt_in;
      acc_ff       <= acc_in;
      cp_ff        <= cp_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      g_ff         <= g_in;
      sc_ff        <= sc_in;
      segx2_ff     <= segx2_in;
      i_ff         <= i_in;
      startc_ff    <= startc_in;
      deltas_ff    <= deltas_in;
      ranges_ff    <= ranges_in;
      startv_ff    <= startv_in;
      delta_ff     <= delta_in;
      first_ff     <= first_in;
      res_glyph_ff <= res_glyph_in;
      res_ovf_ff   <= res_ovf_in;
      rsp_glyph_ff <= rsp_glyph_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

endmodule
`default_nettype wire

### rtl/fcgl_checker.sv
// Port-level checker for the cmap glyph lookup, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module fcgl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_action,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_glyph_id,
   input wire logic        rsp_read_overflow
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_glyph_id) && $stable(rsp_read_overflow), "stalled response changed")
   `ASSERT_IMPL(a_ovf_zero, clock, reset, rsp_valid && rsp_read_overflow, rsp_glyph_id == 32'd0, "overflow with nonzero glyph")
   `ASSERT_NEXT(a_write_silent, clock, reset, req_valid && !req_stall && !req_action && !rsp_valid, !rsp_valid, "write request produced a response")

endmodule

bind font_cmap_glyph_lookup_top fcgl_checker u_fcgl_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_action        (req_action),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_glyph_id      (rsp_glyph_id),
   .rsp_read_overflow (rsp_read_overflow)
);
`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the cmap glyph lookup block (formats 12, 4, 6 and an unused format).
`timescale 1ns / 1ps
module testbench;
   import fcgl_pkg::*;

   localparam logic [1:0] FMT_UNUSED  = 2'd3;
   localparam int         MEM_BYTES   = 65536;
   localparam int         STALL_LIMIT = 20000;
   localparam int         LONG_HOLD   = 400;
   localparam int         SETTLE_CYC  = 40;

   typedef struct packed {
      logic [31:0] glyph;
      logic        ovf;
   } glyph_result_type;

   typedef enum int {
      LAY_F12, LAY_F12_OVF, LAY_F4, LAY_F4_OVF, LAY_F6, LAY_F6_OVF, LAY_UNUSED
   } layout_type;

   typedef struct {
      layout_type  lay;
      logic [20:0] cp;
      bit          fixed;
      logic [31:0] glyph;
      logic        ovf;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [15:0] req_byte_address;
   logic [7:0]  req_byte_value;
   logic [20:0] req_codepoint;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_glyph_id;
   logic        rsp_read_overflow;
   logic        csr_write_enable;
   logic [1:0]  csr_write_data;

   font_cmap_glyph_lookup_top #(.MEM_ADDR_BITS(16)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_byte_address (req_byte_address),
      .req_byte_value   (req_byte_value),
      .req_codepoint    (req_codepoint),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_glyph_id     (rsp_glyph_id),
      .rsp_read_overflow(rsp_read_overflow),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // shadow of the subtable memory and format register
   logic [7:0]       sub_mem     [MEM_BYTES];
   bit               sub_written [MEM_BYTES];
   logic [1:0]       fmt_shadow;
   bit               rd_ovf, rd_hole;
   glyph_result_type pending_glyphs[$];

   int  errors, n_lookups, n_writes, n_ovf, n_hits, n_results;
   bit  no_idle;
   int  hold_asked, hold_done, hold_left, rsp_wait, idle_cycles;
   int unsigned r_lo[$], r_hi[$];

   function automatic logic [31:0] fetch_be(longint unsigned a, int n);
      logic [31:0]    v;
      longint unsigned x;
      v = 0;
      for (int k = 0; k < n; k++) begin
         x = a + k;
         if (x >= MEM_BYTES) begin
            rd_ovf = 1;
            return 0;
         end
         if (!sub_written[x]) rd_hole = 1;
         v = {v[23:0], sub_mem[x]};
      end
      return v;
   endfunction

   function automatic glyph_result_type map_codepoint(logic [20:0] cp);
      glyph_result_type r;
      logic [31:0]      g, sc, ec, endv, startv, delta, ro, gv, first, count;
      longint unsigned  lo, hi, mid, grp, segx2, segs, startc, deltas, ranges;
      rd_ovf  = 0;
      rd_hole = 0;
      g       = 0;
      case (fmt_shadow)
         FMT_12: begin
            lo = 0;
            hi = fetch_be(12, 4);
            if (!rd_ovf) begin
               while (lo < hi) begin
                  mid = lo + ((hi - lo) >> 1);
                  grp = 16 + mid * 12;
                  sc  = fetch_be(grp, 4);
                  ec  = fetch_be(grp + 4, 4);
                  if (rd_ovf) break;
                  if (cp < sc) hi = mid;
                  else if (cp > ec) lo = mid + 1;
                  else begin
                     g = fetch_be(grp + 8, 4) + ({11'd0, cp} - sc);
                     break;
                  end
               end
            end
         end
         FMT_4: begin
            // codepoints above the basic plane never touch memory
            if (cp <= 21'h00FFFF) begin
               segx2 = fetch_be(6, 2);
               if (!rd_ovf) begin
                  segs   = segx2 / 2;
                  startc = 14 + segx2 + 2;
                  deltas = startc + segx2;
                  ranges = deltas + segx2;
                  for (longint unsigned i = 0; i < segs; i++) begin
                     endv = fetch_be(14 + i * 2, 2);
                     if (rd_ovf) break;
                     if (cp > endv) continue;
                     startv = fetch_be(startc + i * 2, 2);
                     if (rd_ovf || cp < startv) break;
                     delta = fetch_be(deltas + i * 2, 2);
                     ro    = fetch_be(ranges + i * 2, 2);
                     if (rd_ovf) break;
                     if (ro == 0) g = ({11'd0, cp} + delta) & 32'hFFFF;
                     else begin
                        gv = fetch_be(ranges + i * 2 + ro + ({11'd0, cp} - startv) * 2, 2);
                        if (!rd_ovf && gv != 0) g = (gv + delta) & 32'hFFFF;
                     end
                     break;
                  end
               end
            end
         end
         FMT_6: begin
            first = fetch_be(6, 2);
            count = fetch_be(8, 2);
            if (!rd_ovf && cp >= first && cp < first + count)
               g = fetch_be(10 + ({11'd0, cp} - first) * 2, 2);
         end
         default: g = 0;
      endcase
      if (rd_ovf) g = 0;
      r.glyph = g;
      r.ovf   = rd_ovf;
      return r;
   endfunction

   task automatic send_req(bit act, logic [15:0] addr, logic [7:0] val, logic [20:0] cp,
                           bit fixed = 0, glyph_result_type fixed_res = '0);
      int               gap;
      glyph_result_type exp_res;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1;
      req_action       <= act;
      req_byte_address <= addr;
      req_byte_value   <= val;
      req_codepoint    <= cp;
      do @(posedge clock); while (req_stall);
      if (!act) begin
         sub_mem[addr]     = val;
         sub_written[addr] = 1;
         n_writes++;
      end else begin
         exp_res = map_codepoint(cp);
         if (fixed) exp_res = fixed_res;
         pending_glyphs.push_back(exp_res);
         n_lookups++;
         if (exp_res.ovf) n_ovf++;
         if (exp_res.glyph != 0) n_hits++;
      end
   endtask

   task automatic put_be(int unsigned addr, int n, logic [31:0] value);
      for (int k = 0; k < n; k++)
         send_req(0, 16'(addr + k), 8'(value >> (8 * (n - 1 - k))), 21'd0);
   endtask

   // drop valid, wait for all results, then let the block go quiet
   task automatic settle();
      req_valid <= 0;
      while (pending_glyphs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic set_format(logic [1:0] f);
      csr_write_enable <= 1;
      csr_write_data   <= f;
      @(posedge clock);
      csr_write_enable <= 0;
      fmt_shadow = f;
   endtask

   task automatic load_layout(layout_type lay);
      settle();
      case (lay)
         LAY_F12, LAY_F12_OVF: begin
            set_format(FMT_12);
            if (lay == LAY_F12_OVF) put_be(12, 4, 32'hFFFF_FFFF);
            else begin
               put_be(12, 4, 2);
               put_be(16, 4, 32'h41);
               put_be(20, 4, 32'h5A);
               put_be(24, 4, 10);
               put_be(28, 4, 32'h10000);
               put_be(32, 4, 32'h10FFFF);
               put_be(36, 4, 32'hFFFF_FF00);
            end
         end
         LAY_F4, LAY_F4_OVF: begin
            set_format(FMT_4);
            if (lay == LAY_F4_OVF) begin
               put_be(6, 2, 16'hFFFE);
               put_be(14, 2, 16'hFFFF);
            end else begin
               put_be(6, 2, 6);
               put_be(14, 2, 16'h0050);
               put_be(16, 2, 16'h0200);
               put_be(18, 2, 16'hFFFF);
               put_be(20, 2, 0);
               put_be(22, 2, 16'h0041);
               put_be(24, 2, 16'h0100);
               put_be(26, 2, 16'hFFFF);
               put_be(28, 2, 5);
               put_be(30, 2, 16'hFFF0);
               put_be(32, 2, 1);
               put_be(34, 2, 0);
               put_be(36, 2, 4);
               put_be(38, 2, 0);
               put_be(40, 2, 16'h1234);
               put_be(42, 2, 0);
            end
         end
         LAY_F6, LAY_F6_OVF: begin
            set_format(FMT_6);
            if (lay == LAY_F6_OVF) begin
               put_be(6, 2, 0);
               put_be(8, 2, 16'hFFFF);
            end else begin
               put_be(6, 2, 16'h20);
               put_be(8, 2, 3);
               put_be(10, 2, 7);
               put_be(12, 2, 16'hFFFF);
               put_be(14, 2, 0);
            end
         end
         default: set_format(FMT_UNUSED);
      endcase
   endtask

   // random subtable, well formed unless broken is set
   task automatic build_subtable(logic [1:0] f, bit broken);
      int unsigned n, wide, cur, sc, ec, st, en, a, ro, first, cnt;
      r_lo.delete();
      r_hi.delete();
      case (f)
         FMT_12: begin
            n    = $urandom_range(1, 10);
            wide = $urandom_range(0, 1);
            cur  = $urandom_range(0, 255);
            put_be(12, 4, broken ? ($urandom | 32'h8000_0000) : n);
            for (int i = 0; i < n; i++) begin
               sc = cur + $urandom_range(0, wide ? 32'h20000 : 32'h100);
               ec = sc + $urandom_range(0, wide ? 32'h4000 : 40);
               put_be(16 + 12 * i, 4, sc);
               put_be(20 + 12 * i, 4, ec);
               put_be(24 + 12 * i, 4, $urandom);
               r_lo.push_back(sc);
               r_hi.push_back(ec);
               cur = ec + 1;
            end
         end
         FMT_4: begin
            n   = $urandom_range(1, 8);
            cur = $urandom_range(0, 16'h4000);
            a   = 16 + 8 * n;
            put_be(6, 2, 2 * n);
            put_be(14 + 2 * n, 2, 0);
            for (int i = 0; i < n; i++) begin
               st = cur + $urandom_range(0, 16'h800);
               en = st + $urandom_range(0, 12);
               if (i == n - 1 && $urandom_range(0, 1)) begin
                  st = 16'hFFFF;
                  en = 16'hFFFF;
               end
               cur = en + 1;
               put_be(14 + 2 * i, 2, en);
               put_be(16 + 2 * n + 2 * i, 2, st);
               put_be(16 + 4 * n + 2 * i, 2, $urandom_range(0, 16'hFFFF));
               r_lo.push_back(st);
               r_hi.push_back(en);
               if (broken && i == 0) ro = 16'hFFF0;    // points past the end of memory
               else if ($urandom_range(0, 1)) ro = 0;
               else begin
                  ro = a - (16 + 6 * n + 2 * i);
                  for (int unsigned c = st; c <= en; c++) begin
                     put_be(a, 2, ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 16'hFFFF));
                     a += 2;
                  end
               end
               put_be(16 + 6 * n + 2 * i, 2, ro);
            end
         end
         FMT_6: begin
            first = $urandom_range(0, 16'hFFF0);
            cnt   = broken ? 16'hFFFF : $urandom_range(1, 30);
            put_be(6, 2, first);
            put_be(8, 2, cnt);
            for (int i = 0; i < (broken ? 4 : cnt); i++)
               put_be(10 + 2 * i, 2, $urandom_range(0, 16'hFFFF));
            r_lo.push_back(first);
            r_hi.push_back(broken ? first + 3 : first + cnt - 1);
            if (broken) begin
               r_lo.push_back(first + 16'h7FFB);
               r_hi.push_back(first + 16'h8010);
            end
         end
         default: ;
      endcase
   endtask

   function automatic logic [20:0] pick_codepoint();
      int unsigned i, lo, hi;
      if (r_lo.size() == 0 || $urandom_range(0, 4) == 0)
         return 21'($urandom_range(0, 21'h1FFFFF));
      i  = $urandom_range(0, r_lo.size() - 1);
      lo = (r_lo[i] > 2) ? r_lo[i] - 2 : 0;
      hi = (r_hi[i] + 2 > 21'h1FFFFF) ? 21'h1FFFFF : r_hi[i] + 2;
      return 21'($urandom_range(lo, hi));
   endfunction

   // response side: check, then draw a stall per result, plus the long hold
   always @(posedge clock) begin
      glyph_result_type want;
      if (reset) begin
         rsp_stall <= 0;
         rsp_wait  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (pending_glyphs.size() == 0) begin
               $display("%0t: unexpected result glyph %h overflow %b", $time,
                        rsp_glyph_id, rsp_read_overflow);
               errors++;
            end else begin
               want = pending_glyphs.pop_front();
               if (rsp_glyph_id !== want.glyph) begin
                  $display("%0t: glyph_id expected %h actual %h", $time, want.glyph,
                           rsp_glyph_id);
                  errors++;
               end
               if (rsp_read_overflow !== want.ovf) begin
                  $display("%0t: read_overflow expected %b actual %b", $time, want.ovf,
                           rsp_read_overflow);
                  errors++;
               end
            end
            rsp_wait = no_idle ? 0 : $urandom_range(0, 15);
         end else if (rsp_wait > 0) rsp_wait--;
         if (hold_done != hold_asked) begin
            hold_done++;
            hold_left = LONG_HOLD;
         end else if (hold_left > 0) hold_left--;
         rsp_stall <= (rsp_wait > 0) || (hold_left > 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("font_cmap_glyph_lookup_top: mismatch");
         $finish;
      end
   end

   dir_row_type directed[$] = '{
      '{LAY_F12,     21'h000000, 1, 32'd0,  1'b0},
      '{LAY_F12,     21'h000041, 1, 32'd10, 1'b0},
      '{LAY_F12,     21'h00005A, 0, 32'd0,  1'b0},
      '{LAY_F12,     21'h00005B, 1, 32'd0,  1'b0},
      '{LAY_F12,     21'h010000, 0, 32'd0,  1'b0},
      '{LAY_F12,     21'h10FFFF, 0, 32'd0,  1'b0},
      '{LAY_F12,     21'h1FFFFF, 1, 32'd0,  1'b0},
      '{LAY_F12_OVF, 21'h000041, 1, 32'd0,  1'b1},
      '{LAY_F4,      21'h000040, 1, 32'd0,  1'b0},
      '{LAY_F4,      21'h000041, 0, 32'd0,  1'b0},
      '{LAY_F4,      21'h000050, 0, 32'd0,  1'b0},
      '{LAY_F4,      21'h000100, 0, 32'd0,  1'b0},
      '{LAY_F4,      21'h000101, 1, 32'd0,  1'b0},
      '{LAY_F4,      21'h00FFFF, 0, 32'd0,  1'b0},
      '{LAY_F4,      21'h010000, 1, 32'd0,  1'b0},
      '{LAY_F4,      21'h1FFFFF, 1, 32'd0,  1'b0},
      '{LAY_F4_OVF,  21'h00FFFF, 1, 32'd0,  1'b1},
      '{LAY_F6,      21'h00001F, 1, 32'd0,  1'b0},
      '{LAY_F6,      21'h000020, 1, 32'd7,  1'b0},
      '{LAY_F6,      21'h000021, 1, 32'hFFFF, 1'b0},
      '{LAY_F6,      21'h000022, 1, 32'd0,  1'b0},
      '{LAY_F6,      21'h000023, 1, 32'd0,  1'b0},
      '{LAY_F6_OVF,  21'h008000, 1, 32'd0,  1'b1},
      '{LAY_UNUSED,  21'h000041, 1, 32'd0,  1'b0}
   };

   initial begin
      layout_type       cur_lay;
      logic [1:0]       f;
      logic [20:0]      cp;
      glyph_result_type probe;
      bit               ok;
      reset            = 1;
      req_valid        = 0;
      req_action       = 0;
      req_byte_address = 0;
      req_byte_value   = 0;
      req_codepoint    = 0;
      csr_write_enable = 0;
      csr_write_data   = 0;
      fmt_shadow       = FMT_12;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      for (int r = 0; r < directed.size(); r++) begin
         if (r == 0 || directed[r].lay != cur_lay) begin
            load_layout(directed[r].lay);
            cur_lay = directed[r].lay;
         end
         send_req(1, 16'd0, 8'd0, directed[r].cp, directed[r].fixed,
                  '{glyph: directed[r].glyph, ovf: directed[r].ovf});
      end

      for (int ph = 0; ph < 14; ph++) begin
         settle();
         case (ph % 4)
            0: f = FMT_12;
            1: f = FMT_4;
            2: f = FMT_6;
            default: f = FMT_UNUSED;
         endcase
         set_format(f);
         no_idle = (ph == 5);
         build_subtable(f, $urandom_range(0, 5) == 0);
         if (ph == 2) hold_asked++;
         for (int k = 0; k < 35; k++) begin
            ok = 0;
            if ($urandom_range(0, 7) != 0) begin
               for (int t = 0; t < 10 && !ok; t++) begin
                  cp    = pick_codepoint();
                  probe = map_codepoint(cp);
                  ok    = !rd_hole;
               end
            end
            if (ok) send_req(1, 16'd0, 8'd0, cp);
            else send_req(0, 16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)),
                          21'd0);
         end
         no_idle = 0;
      end

      settle();
      $display("Ran %0d lookups and %0d byte writes across formats 12, 4, 6 and unused;",
               n_lookups, n_writes);
      $display("%0d results seen, %0d mapped a glyph, %0d ran past memory.", n_results,
               n_hits, n_ovf);
      if (errors == 0) $display("font_cmap_glyph_lookup_top: match");
      else $display("font_cmap_glyph_lookup_top: mismatch");
      $finish;
   end

endmodule
